// ----- hdl/bscl_pkg.sv -----
// Shared types and constants for the band scale category layout block.
// No dependencies; imported by the top level and the category table.
package bscl_pkg;

    localparam int FRAC_BITS          = 16;
    localparam int MAX_CATEGORIES_DEF = 64;
    localparam int DATA_W             = 32;
    // Signed width of every layout numerator, denominator and quotient
    localparam int SW                 = FRAC_BITS + 36;
    localparam int INNER_W            = FRAC_BITS + 1;
    localparam int OUTER_W            = FRAC_BITS + 2;
    localparam int CFG_IDX_W          = 2;

    localparam logic [INNER_W-1:0] ONE_Q     = INNER_W'(1) << FRAC_BITS;
    localparam logic [OUTER_W-1:0] TWO_Q     = OUTER_W'(1) << (FRAC_BITS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_PAD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_PAD   = 2'd3;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_CENTER = 3'd3;
    localparam logic [2:0] OP_INVERT = 3'd4;

endpackage

// ----- hdl/bscl_table.sv -----
// Category code store: one write port, one registered read port.
// Depends on bscl_pkg for the code width.
module bscl_table #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [IDX_W-1:0]           waddr,
    input  logic [bscl_pkg::DATA_W-1:0] wdata,
    input  logic [IDX_W-1:0]           raddr,
    output logic [bscl_pkg::DATA_W-1:0] rdata
);
    import bscl_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bscl_div.sv -----
// Shared signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone; the top level sequences all layout and invert quotients through it.
module bscl_div #(
    parameter int W = 52
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] num,
    input  logic signed [W-1:0] den,
    output logic                done,
    output logic signed [W-1:0] quot,
    output logic                rem_nz
);
    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dmag_reg, dmag_next;
    logic             negq_reg, negq_next;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dmag_next = dmag_reg;
        negq_next = negq_reg;
        shifted   = {rem_reg[W-1:0], dvd_reg[W-1]};
        trial     = shifted - {1'b0, dmag_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            dvd_next  = num[W-1] ? W'(-num) : W'(num);
            dmag_next = den[W-1] ? W'(-den) : W'(den);
            negq_next = num[W-1] ^ den[W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial;
                dvd_next = {dvd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                dvd_next = {dvd_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dmag_reg <= dmag_next;
        negq_reg <= negq_next;
    end

    assign done   = done_reg;
    assign quot   = negq_reg ? $signed(-dvd_reg) : $signed(dvd_reg);
    assign rem_nz = (rem_reg != '0);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg > CNT_W'(1) |=> busy_reg)
        else $error("divider stopped early");

endmodule

// ----- hdl/band_scale_category_layout_top.sv -----
// Band scale category layout: ordered code table plus band layout and invert.
// Clear, unused operation codes and invert on an empty table end at once; add scans the codes;
// start and center scan, divide for step and offset (center also for the band), or end on a code
// not found; invert divides step, offset and (nonzero step) index, then reads the code in range.
// Throughput: one request at a time, in_stall high until the result moves to the output register.
// Reset (async, rst_n low) empties the table and restores the range to [0, 1.0], no padding.
module band_scale_category_layout_top #(
    parameter int MAX_CATEGORIES = bscl_pkg::MAX_CATEGORIES_DEF,
    parameter int CNT_W = $clog2(MAX_CATEGORIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    operation,
    input  logic [bscl_pkg::DATA_W-1:0]   category_code,
    input  logic signed [bscl_pkg::DATA_W-1:0] position_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [bscl_pkg::DATA_W-1:0] position_out,
    output logic [bscl_pkg::DATA_W-1:0]   code_out,
    output logic                          found,
    output logic [CNT_W-1:0]              category_count,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bscl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bscl_pkg::DATA_W-1:0]   cfg_data
);
    import bscl_pkg::*;

    localparam int IDX_W = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int PW    = SW + CNT_W;
    localparam int SUM_W = PW + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sh80000000);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_SEARCH   = 11'b00000000010,
        ST_DIV_STEP = 11'b00000000100,
        ST_DIV_OFF  = 11'b00000001000,
        ST_DIV_BAND = 11'b00000010000,
        ST_MUL      = 11'b00000100000,
        ST_SUM      = 11'b00001000000,
        ST_DIV_INV  = 11'b00010000000,
        ST_FETCH    = 11'b00100000000,
        ST_READ     = 11'b01000000000,
        ST_DONE     = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic signed [DATA_W-1:0] r0_reg, r1_reg;
    logic [INNER_W-1:0]       inner_reg;
    logic [OUTER_W-1:0]       outer_reg;

    // request and working registers
    logic [2:0]               op_reg, op_next;
    logic [DATA_W-1:0]        code_reg, code_next;
    logic signed [DATA_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         scan_reg, scan_next;
    logic                     cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]         fetch_idx_reg, fetch_idx_next;
    logic signed [SW-1:0]     step_reg, step_next;
    logic signed [SW-1:0]     off_reg, off_next;
    logic signed [SW-1:0]     band_reg, band_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic                     div_start_reg, div_start_next;

    // result being built and output registers
    logic signed [DATA_W-1:0] res_pos_reg, res_pos_next;
    logic [DATA_W-1:0]        res_code_reg, res_code_next;
    logic                     res_found_reg, res_found_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_pos_reg, out_pos_next;
    logic [DATA_W-1:0]        out_code_reg, out_code_next;
    logic                     out_found_reg, out_found_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    // table port
    logic                     tbl_we;
    logic [IDX_W-1:0]         tbl_raddr;
    logic [DATA_W-1:0]        tbl_rdata;

    // divider port
    logic signed [SW-1:0]     div_num, div_den;
    logic                     div_done;
    logic signed [SW-1:0]     div_quot;
    logic                     div_rem_nz;

    // layout terms
    logic signed [DATA_W:0]   extent;
    logic signed [DATA_W:0]   mid_sum;
    logic signed [DATA_W:0]   mid_half;
    logic [INNER_W-1:0]       pad_in;
    logic [INNER_W-1:0]       one_minus_in;
    logic [OUTER_W-1:0]       pad_out;
    logic signed [SW-1:0]     denom_raw, denom;
    logic signed [SW-1:0]     step_num, band_num, off_num, inv_num;
    logic signed [SW:0]       floor_q;
    logic                     inv_adj;
    logic signed [SW-1:0]     half_band;
    logic signed [SUM_W-1:0]  pos_sum;
    logic signed [DATA_W-1:0] pos_sat;
    logic                     in_accept;
    logic                     out_accept;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        extent       = $signed({r1_reg[DATA_W-1], r1_reg}) - $signed({r0_reg[DATA_W-1], r0_reg});
        mid_sum      = $signed({r0_reg[DATA_W-1], r0_reg}) + $signed({r1_reg[DATA_W-1], r1_reg});
        mid_half     = (mid_sum + $signed({{DATA_W{1'b0}}, mid_sum[DATA_W]})) >>> 1;
        pad_in       = (inner_reg > ONE_Q) ? ONE_Q : inner_reg;
        one_minus_in = ONE_Q - pad_in;
        pad_out      = (outer_reg > TWO_Q) ? TWO_Q : outer_reg;
        denom_raw    = ($signed(SW'(count_reg)) <<< FRAC_BITS) - $signed(SW'(pad_in))
                     + ($signed(SW'(pad_out)) <<< 1);
        denom        = (denom_raw <= 0) ? $signed(SW'(ONE_Q)) : denom_raw;
        step_num     = $signed(SW'(extent)) <<< FRAC_BITS;
        band_num     = $signed(SW'(extent)) * $signed(SW'({1'b0, one_minus_in}));
        off_num      = $signed(SW'(extent)) * $signed(SW'({1'b0, pad_out}));
        inv_num      = $signed(SW'(pos_reg)) - $signed(SW'(r0_reg)) - off_reg;
        inv_adj      = div_rem_nz && (inv_num[SW-1] != step_reg[SW-1]);
        floor_q      = $signed({div_quot[SW-1], div_quot}) - $signed((SW+1)'(inv_adj));
        half_band    = (band_reg + $signed(SW'(band_reg[SW-1]))) >>> 1;
        pos_sum      = $signed(SUM_W'(r0_reg)) + $signed(SUM_W'(off_reg))
                     + $signed(SUM_W'(prod_reg))
                     + ((op_reg == OP_CENTER) ? $signed(SUM_W'(half_band)) : '0);
        if (pos_sum > SAT_MAX)
        begin
            pos_sat = 32'sh7FFFFFFF;
        end
        else if (pos_sum < SAT_MIN)
        begin
            pos_sat = 32'sh80000000;
        end
        else
        begin
            pos_sat = pos_sum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_DIV_STEP:
            begin
                div_num = step_num;
                div_den = denom;
            end
            ST_DIV_OFF:
            begin
                div_num = off_num;
                div_den = denom;
            end
            ST_DIV_BAND:
            begin
                div_num = band_num;
                div_den = denom;
            end
            default:
            begin
                div_num = inv_num;
                div_den = step_reg;
            end
        endcase
    end

    assign tbl_we    = (state_reg == ST_SEARCH) && !(cmp_vld_reg && tbl_rdata == code_reg)
                     && !cmp_vld_reg && !(scan_reg < count_reg)
                     && (op_reg == OP_ADD) && (count_reg < CNT_W'(MAX_CATEGORIES));
    assign tbl_raddr = (state_reg == ST_SEARCH) ? scan_reg[IDX_W-1:0] : fetch_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        code_next      = code_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_idx_next   = hit_idx_reg;
        fetch_idx_next = fetch_idx_reg;
        step_next      = step_reg;
        off_next       = off_reg;
        band_next      = band_reg;
        prod_next      = prod_reg;
        res_pos_next   = res_pos_reg;
        res_code_next  = res_code_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !out_accept;
        out_pos_next   = out_pos_reg;
        out_code_next  = out_code_reg;
        out_found_next = out_found_reg;
        out_count_next = out_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = operation;
                    code_next      = category_code;
                    pos_next       = position_in;
                    res_pos_next   = '0;
                    res_code_next  = '0;
                    res_found_next = 1'b0;
                    scan_next      = '0;
                    case (operation)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        OP_ADD, OP_START, OP_CENTER:
                        begin
                            state_next = ST_SEARCH;
                        end
                        OP_INVERT:
                        begin
                            state_next = (count_reg == '0) ? ST_DONE : ST_DIV_STEP;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                // issue one read a cycle, compare the word that came back
                if (scan_reg < count_reg)
                begin
                    scan_next    = scan_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg && tbl_rdata == code_reg)
                begin
                    cmp_vld_next = 1'b0;
                    hit_idx_next = cmp_idx_reg;
                    if (op_reg == OP_ADD)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        res_found_next = 1'b1;
                        state_next     = ST_DIV_STEP;
                    end
                end
                else if (!cmp_vld_reg && !(scan_reg < count_reg))
                begin
                    if (op_reg == OP_ADD)
                    begin
                        if (tbl_we)
                        begin
                            count_next     = count_reg + CNT_W'(1);
                            res_found_next = 1'b1;
                        end
                    end
                    else
                    begin
                        res_pos_next = mid_half[DATA_W-1:0];
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DIV_STEP:
            begin
                if (div_done)
                begin
                    step_next  = div_quot;
                    state_next = ST_DIV_OFF;
                end
            end
            ST_DIV_OFF:
            begin
                if (div_done)
                begin
                    off_next = div_quot;
                    if (op_reg == OP_CENTER)
                    begin
                        state_next = ST_DIV_BAND;
                    end
                    else if (op_reg == OP_START)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (step_reg == '0)
                    begin
                        fetch_idx_next = '0;
                        state_next     = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_DIV_INV;
                    end
                end
            end
            ST_DIV_BAND:
            begin
                if (div_done)
                begin
                    band_next  = div_quot;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = $signed(PW'({1'b0, hit_idx_reg})) * $signed(PW'(step_reg));
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                res_pos_next = pos_sat;
                state_next   = ST_DONE;
            end
            ST_DIV_INV:
            begin
                if (div_done)
                begin
                    if (floor_q >= 0 && floor_q < $signed((SW+1)'(count_reg)))
                    begin
                        fetch_idx_next = floor_q[IDX_W-1:0];
                        state_next     = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                res_code_next  = tbl_rdata;
                res_found_next = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_accept)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = res_pos_reg;
                    out_code_next  = res_code_reg;
                    out_found_next = res_found_reg;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        div_start_next = (state_next != state_reg)
                       && (state_next == ST_DIV_STEP || state_next == ST_DIV_OFF
                           || state_next == ST_DIV_BAND || state_next == ST_DIV_INV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            r0_reg        <= '0;
            r1_reg        <= 32'sh00010000;
            inner_reg     <= '0;
            outer_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RANGE_START: r0_reg    <= cfg_data;
                    CFG_RANGE_END:   r1_reg    <= cfg_data;
                    CFG_INNER_PAD:   inner_reg <= cfg_data[INNER_W-1:0];
                    CFG_OUTER_PAD:   outer_reg <= cfg_data[OUTER_W-1:0];
                    default:         r0_reg    <= r0_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        code_reg      <= code_next;
        pos_reg       <= pos_next;
        scan_reg      <= scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        fetch_idx_reg <= fetch_idx_next;
        step_reg      <= step_next;
        off_reg       <= off_next;
        band_reg      <= band_next;
        prod_reg      <= prod_next;
        res_pos_reg   <= res_pos_next;
        res_code_reg  <= res_code_next;
        res_found_reg <= res_found_next;
        out_pos_reg   <= out_pos_next;
        out_code_reg  <= out_code_next;
        out_found_reg <= out_found_next;
        out_count_reg <= out_count_next;
    end

    bscl_table #(
        .DEPTH (MAX_CATEGORIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (code_reg),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    bscl_div #(
        .W (SW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start_reg),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quot   (div_quot),
        .rem_nz (div_rem_nz)
    );

    assign out_valid      = out_valid_reg;
    assign position_out   = out_pos_reg;
    assign code_out       = out_code_reg;
    assign found          = out_found_reg;
    assign category_count = out_count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CATEGORIES))
        else $error("category count beyond table depth");
    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> count_reg < CNT_W'(MAX_CATEGORIES))
        else $error("table write with full table");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg != ST_IDLE)
        else $error("accepted request did not start");
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_STEP || state_reg == ST_DIV_OFF
                      || state_reg == ST_DIV_BAND || state_reg == ST_DIV_INV))
        else $error("quotient arrived outside a division step");

endmodule
